// ===== hw/rtl/sscfc_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package sscfc_pkg;

    // Counter width default for the forced-object totals
    localparam int COUNT_BITS_DEFAULT = 32;

    // Input operations
    localparam logic OP_DATA = 1'b0;
    localparam logic OP_END  = 1'b1;

    // Report kinds
    localparam logic KIND_SEGMENT = 1'b0;
    localparam logic KIND_TOTALS  = 1'b1;

    // Status codes
    localparam logic [1:0] STATUS_OK      = 2'd0;
    localparam logic [1:0] STATUS_LEN_ERR = 2'd1;
    localparam logic [1:0] STATUS_TRUNC   = 2'd2;

    // Segment types
    localparam logic [7:0] TYPE_PDS = 8'h14;
    localparam logic [7:0] TYPE_ODS = 8'h15;
    localparam logic [7:0] TYPE_PCS = 8'h16;
    localparam logic [7:0] TYPE_WDS = 8'h17;
    localparam logic [7:0] TYPE_END = 8'h80;

    // Presentation segment layout
    localparam logic [15:0] PCS_COUNT_OFFSET = 16'd10;
    localparam logic [15:0] PCS_OBJ_BASE     = 16'd11;
    localparam logic [2:0]  OBJ_FLAG_BYTE    = 3'd3;
    localparam int          FORCED_BIT       = 6;

    typedef struct packed {
        logic       operation;
        logic [7:0] data_byte;
    } in_item_t;

    typedef struct packed {
        logic        report_kind;
        logic [7:0]  type_code;
        logic [15:0] payload_len;
        logic        unknown_type;
        logic [7:0]  segment_forced;
        logic [31:0] total_forced_objects;
        logic [31:0] total_forced_presentations;
        logic [1:0]  status;
    } out_item_t;

endpackage

`default_nettype wire

// ===== hw/rtl/sscfc_parser.sv =====
`timescale 1ns / 1ps
`default_nettype none

module sscfc_parser
    import sscfc_pkg::*;
#(
    parameter int COUNT_BITS = COUNT_BITS_DEFAULT
)
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      step,
    input  wire in_item_t  item,
    output logic           result_valid,
    output out_item_t      result,
    output logic           error_flag
);

    localparam logic [1:0] PH_TYPE    = 2'd0;
    localparam logic [1:0] PH_LEN_HI  = 2'd1;
    localparam logic [1:0] PH_LEN_LO  = 2'd2;
    localparam logic [1:0] PH_PAYLOAD = 2'd3;

    localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

    logic [1:0]            phase_reg,      phase_next;
    logic [7:0]            type_reg,       type_next;
    logic [15:0]           length_reg,     length_next;
    logic [15:0]           offset_reg,     offset_next;
    logic [7:0]            count_reg,      count_next;
    logic [7:0]            forced_reg,     forced_next;
    logic [COUNT_BITS-1:0] obj_total_reg,  obj_total_next;
    logic [COUNT_BITS-1:0] pres_total_reg, pres_total_next;
    logic                  error_reg,      error_next;

    logic                  finish;
    logic                  is_pcs;
    logic                  length_ok;
    logic [15:0]           rel;
    logic [16:0]           expected;
    logic [16:0]           off_inc;
    logic [7:0]            seg_forced;
    logic [COUNT_BITS:0]   obj_sum;
    logic [COUNT_BITS:0]   pres_sum;
    logic [1:0]            end_status;

    always_comb
    begin
        phase_next      = phase_reg;
        type_next       = type_reg;
        length_next     = length_reg;
        offset_next     = offset_reg;
        count_next      = count_reg;
        forced_next     = forced_reg;
        obj_total_next  = obj_total_reg;
        pres_total_next = pres_total_reg;
        error_next      = error_reg;
        finish          = 1'b0;
        result_valid    = 1'b0;
        result          = '0;

        is_pcs  = (type_reg == TYPE_PCS);
        rel     = offset_reg - PCS_OBJ_BASE;
        off_inc = {1'b0, offset_reg} + 17'd1;

        if (phase_reg == PH_PAYLOAD)
        begin
            end_status = STATUS_TRUNC;
        end
        else
        begin
            end_status = error_reg ? STATUS_LEN_ERR : STATUS_OK;
        end

        if (step && item.operation == OP_END)
        begin
            phase_next   = PH_TYPE;
            offset_next  = '0;
            result_valid = 1'b1;
            result.report_kind                = KIND_TOTALS;
            result.total_forced_objects       = 32'(obj_total_reg);
            result.total_forced_presentations = 32'(pres_total_reg);
            result.status                     = end_status;
        end
        else if (step)
        begin
            case (phase_reg)
                PH_TYPE:
                begin
                    type_next   = item.data_byte;
                    length_next = '0;
                    offset_next = '0;
                    count_next  = '0;
                    forced_next = '0;
                    phase_next  = PH_LEN_HI;
                end
                PH_LEN_HI:
                begin
                    length_next = {item.data_byte, 8'h00};
                    phase_next  = PH_LEN_LO;
                end
                PH_LEN_LO:
                begin
                    length_next = {length_reg[15:8], item.data_byte};
                    if (length_next == 16'd0)
                    begin
                        finish = 1'b1;
                    end
                    else
                    begin
                        phase_next = PH_PAYLOAD;
                    end
                end
                default:
                begin
                    if (is_pcs)
                    begin
                        if (offset_reg == PCS_COUNT_OFFSET)
                        begin
                            count_next = item.data_byte;
                        end
                        else if (offset_reg >= PCS_OBJ_BASE
                                 && rel[2:0] == OBJ_FLAG_BYTE
                                 && rel[15:3] < {5'b0, count_reg}
                                 && item.data_byte[FORCED_BIT])
                        begin
                            forced_next = forced_reg + 8'd1;
                        end
                    end
                    offset_next = off_inc[15:0];
                    if (off_inc >= {1'b0, length_reg})
                    begin
                        finish = 1'b1;
                    end
                end
            endcase
        end

        // Close the segment: check presentation length, fold into totals
        expected   = {1'b0, PCS_OBJ_BASE} + {6'b0, count_next, 3'b000};
        length_ok  = ({1'b0, length_next} == expected);
        seg_forced = '0;
        obj_sum    = {1'b0, obj_total_reg} + (COUNT_BITS + 1)'(forced_next);
        pres_sum   = {1'b0, pres_total_reg} + (COUNT_BITS + 1)'(1);

        if (finish)
        begin
            if (is_pcs)
            begin
                if (!length_ok)
                begin
                    error_next = 1'b1;
                end
                else
                begin
                    seg_forced     = forced_next;
                    obj_total_next = obj_sum[COUNT_BITS] ? COUNT_MAX
                                                         : obj_sum[COUNT_BITS-1:0];
                    if (forced_next != 8'd0)
                    begin
                        pres_total_next = pres_sum[COUNT_BITS] ? COUNT_MAX
                                                               : pres_sum[COUNT_BITS-1:0];
                    end
                end
            end
            phase_next   = PH_TYPE;
            offset_next  = '0;
            result_valid = 1'b1;
            result.report_kind                = KIND_SEGMENT;
            result.type_code                  = type_reg;
            result.payload_len                = length_next;
            result.unknown_type               = !(type_reg == TYPE_PDS
                                                  || type_reg == TYPE_ODS
                                                  || type_reg == TYPE_PCS
                                                  || type_reg == TYPE_WDS
                                                  || type_reg == TYPE_END);
            result.segment_forced             = seg_forced;
            result.total_forced_objects       = 32'(obj_total_next);
            result.total_forced_presentations = 32'(pres_total_next);
            result.status                     = error_next ? STATUS_LEN_ERR : STATUS_OK;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_TYPE;
            type_reg       <= '0;
            length_reg     <= '0;
            offset_reg     <= '0;
            count_reg      <= '0;
            forced_reg     <= '0;
            obj_total_reg  <= '0;
            pres_total_reg <= '0;
            error_reg      <= 1'b0;
        end
        else
        begin
            phase_reg      <= phase_next;
            type_reg       <= type_next;
            length_reg     <= length_next;
            offset_reg     <= offset_next;
            count_reg      <= count_next;
            forced_reg     <= forced_next;
            obj_total_reg  <= obj_total_next;
            pres_total_reg <= pres_total_next;
            error_reg      <= error_next;
        end
    end

    assign error_flag = error_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/sscfc_out_buf.sv =====
`timescale 1ns / 1ps
`default_nettype none

module sscfc_out_buf
    import sscfc_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      push,
    input  wire out_item_t push_item,
    output logic           space,
    output logic           valid,
    input  wire logic      stall,
    output out_item_t      item
);

    out_item_t  slot0_reg;
    out_item_t  slot1_reg;
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] cnt_reg,    cnt_next;
    logic       pop;

    assign space = (cnt_reg != 2'd2);
    assign valid = (cnt_reg != 2'd0);
    assign item  = rd_ptr_reg ? slot1_reg : slot0_reg;
    assign pop   = valid && !stall;

    always_comb
    begin
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop  ? !rd_ptr_reg : rd_ptr_reg;
        cnt_next    = cnt_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push && !wr_ptr_reg)
        begin
            slot0_reg <= push_item;
        end
        if (push && wr_ptr_reg)
        begin
            slot1_reg <= push_item;
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/subtitle_segment_forced_counter_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Channel   Direction  Handshake                 Payload
// byte      in         byte_valid / byte_stall   byte_item   (in_item_t)
// report    out        report_valid/report_stall report_item (out_item_t)
//
// One stream byte per cycle while byte_stall is low. A byte waits in the input register,
// is parsed from there and its report, if any, is registered in a two-entry output buffer,
// which raises report_valid. The report is taken at an edge where report_stall is low.
// rst_n clears the parser to header byte zero and zeroes all totals.
// byte_stall rises only when a byte is held and the output buffer is full.

module subtitle_segment_forced_counter_unit
    import sscfc_pkg::*;
#(
    parameter int COUNT_BITS = COUNT_BITS_DEFAULT
)
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      byte_valid,
    output logic           byte_stall,
    input  wire in_item_t  byte_item,
    output logic           report_valid,
    input  wire logic      report_stall,
    output out_item_t      report_item
);

    logic      in_valid_reg, in_valid_next;
    in_item_t  in_item_reg;
    logic      accept;
    logic      step;
    logic      buf_space;
    logic      result_valid;
    out_item_t result;
    logic      error_flag;

    // Hold the byte while the output buffer has no room for its report
    assign byte_stall = in_valid_reg && !buf_space;
    assign accept     = byte_valid && !byte_stall;
    assign step       = in_valid_reg && buf_space;

    always_comb
    begin
        if (accept)
        begin
            in_valid_next = 1'b1;
        end
        else if (step)
        begin
            in_valid_next = 1'b0;
        end
        else
        begin
            in_valid_next = in_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg <= in_valid_next;
        end
    end

    // Capture the payload of each accepted transaction
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            in_item_reg <= byte_item;
        end
    end

    // Parse the held byte and advance segment state
    sscfc_parser #(
        .COUNT_BITS (COUNT_BITS)
    ) u_parser (
        .clk          (clk),
        .rst_n        (rst_n),
        .step         (step),
        .item         (in_item_reg),
        .result_valid (result_valid),
        .result       (result),
        .error_flag   (error_flag)
    );

    // Decouple report delivery from parsing
    sscfc_out_buf u_out_buf (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (step && result_valid),
        .push_item (result),
        .space     (buf_space),
        .valid     (report_valid),
        .stall     (report_stall),
        .item      (report_item)
    );

`ifndef SYNTH
    // Length errors stay latched once seen
    a_error_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        $past(error_flag) |-> error_flag)
        else $error("length error flag cleared");

    // A stalled byte stays in the input register unchanged
    a_hold_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        byte_stall |=> in_valid_reg && $stable(in_item_reg))
        else $error("held byte lost while stalled");

    // A segment report with OK status implies no latched error
    a_status_matches: assert property (@(posedge clk) disable iff (!rst_n)
        step && result_valid && result.report_kind == KIND_SEGMENT
        && result.status == STATUS_OK |=> !error_flag)
        else $error("segment status disagrees with error flag");
`endif

endmodule

`default_nettype wire

// ===== verif/subtitle_segment_forced_counter_unit_tb.sv =====
`timescale 1ns / 1ps

module subtitle_segment_forced_counter_unit_tb;
    import sscfc_pkg::*;

    // Run the block with 8-bit totals; the summary shows how far they climbed.
    localparam int TOTAL_BITS    = 8;
    localparam int RESET_CYCLES  = 7;
    // Settle time after the last drain, to catch stray reports.
    localparam int SETTLE_CYCLES = 8;
    // Watchdog limit in nanoseconds.
    localparam int WATCHDOG_NS   = 2_000_000;
    localparam int OBJ_BYTES     = 8;

    typedef enum logic [1:0] {
        STEP_TYPE,
        STEP_LEN_HI,
        STEP_LEN_LO,
        STEP_PAYLOAD
    } parse_step_e;

    // Mirror of the segment parser: holds its own parse state and totals, and
    // the queue of reports that the block owes us, oldest first.
    class segment_report_board;
        out_item_t   awaited_reports[$];
        parse_step_e step        = STEP_TYPE;
        logic [7:0]  seg_type    = '0;
        logic [15:0] seg_len     = '0;
        logic [15:0] offset      = '0;
        logic [7:0]  obj_count   = '0;
        logic [7:0]  forced_here = '0;
        logic [63:0] obj_total   = '0;
        logic [63:0] pres_total  = '0;
        bit          len_err     = 1'b0;
        int          failures        = 0;
        int          segment_reports = 0;
        int          totals_reports  = 0;

        function logic [63:0] sat_add(logic [63:0] a, logic [63:0] b);
            logic [63:0] top;
            top = (TOTAL_BITS >= 64) ? '1 : (64'd1 << TOTAL_BITS) - 64'd1;
            if (a >= top || b > top - a)
                return top;
            return a + b;
        endfunction

        // Close the current segment: credit a consistent presentation, latch
        // the error on an inconsistent one, queue the segment report.
        function void close_segment();
            out_item_t  r;
            logic [7:0] credited;
            credited = '0;
            if (seg_type == TYPE_PCS)
            begin
                if (32'(seg_len) != 32'(PCS_OBJ_BASE) + 32'(OBJ_BYTES) * 32'(obj_count))
                    len_err = 1'b1;
                else
                begin
                    credited  = forced_here;
                    obj_total = sat_add(obj_total, 64'(credited));
                    if (credited != 0)
                        pres_total = sat_add(pres_total, 64'd1);
                end
            end
            r = '0;
            r.report_kind    = KIND_SEGMENT;
            r.type_code      = seg_type;
            r.payload_len    = seg_len;
            r.unknown_type   = !(seg_type inside {TYPE_PDS, TYPE_ODS, TYPE_PCS, TYPE_WDS,
                                                  TYPE_END});
            r.segment_forced = credited;
            r.total_forced_objects       = obj_total[31:0];
            r.total_forced_presentations = pres_total[31:0];
            r.status         = len_err ? STATUS_LEN_ERR : STATUS_OK;
            awaited_reports.push_back(r);
            step   = STEP_TYPE;
            offset = '0;
        endfunction

        // Advance the parser by one accepted input transaction.
        function void take_byte(in_item_t item);
            out_item_t   r;
            logic [15:0] rel;
            if (item.operation == OP_END)
            begin
                r = '0;
                r.report_kind = KIND_TOTALS;
                r.total_forced_objects       = obj_total[31:0];
                r.total_forced_presentations = pres_total[31:0];
                if (step == STEP_PAYLOAD)
                    r.status = STATUS_TRUNC;
                else
                    r.status = len_err ? STATUS_LEN_ERR : STATUS_OK;
                awaited_reports.push_back(r);
                step   = STEP_TYPE;
                offset = '0;
                return;
            end
            case (step)
                STEP_TYPE:
                begin
                    seg_type    = item.data_byte;
                    seg_len     = '0;
                    offset      = '0;
                    obj_count   = '0;
                    forced_here = '0;
                    step        = STEP_LEN_HI;
                end
                STEP_LEN_HI:
                begin
                    seg_len = {item.data_byte, 8'h00};
                    step    = STEP_LEN_LO;
                end
                STEP_LEN_LO:
                begin
                    seg_len[7:0] = item.data_byte;
                    if (seg_len == 0)
                        close_segment();
                    else
                        step = STEP_PAYLOAD;
                end
                default:
                begin
                    if (seg_type == TYPE_PCS)
                    begin
                        rel = offset - PCS_OBJ_BASE;
                        if (offset == PCS_COUNT_OFFSET)
                            obj_count = item.data_byte;
                        else if (offset >= PCS_OBJ_BASE && rel[2:0] == OBJ_FLAG_BYTE &&
                                 (rel >> 3) < 16'(obj_count) && item.data_byte[FORCED_BIT])
                            forced_here = forced_here + 8'd1;
                    end
                    offset = offset + 16'd1;
                    if (offset >= seg_len)
                        close_segment();
                end
            endcase
        endfunction

        function void compare_field(string field, logic [31:0] want, logic [31:0] got);
            if (want !== got)
            begin
                failures++;
                $display("%0t: report %0d %s expected 0x%0h actual 0x%0h", $time,
                         segment_reports + totals_reports, field, want, got);
            end
        endfunction

        function void check_report(out_item_t got);
            out_item_t want;
            if (awaited_reports.size() == 0)
            begin
                failures++;
                $display("%0t: unexpected report, expected none, actual %h", $time, got);
                return;
            end
            want = awaited_reports.pop_front();
            if (want.report_kind == KIND_TOTALS)
                totals_reports++;
            else
                segment_reports++;
            compare_field("report_kind", want.report_kind, got.report_kind);
            compare_field("type_code", want.type_code, got.type_code);
            compare_field("payload_len", want.payload_len, got.payload_len);
            compare_field("unknown_type", want.unknown_type, got.unknown_type);
            compare_field("segment_forced", want.segment_forced, got.segment_forced);
            compare_field("total_forced_objects", want.total_forced_objects,
                          got.total_forced_objects);
            compare_field("total_forced_presentations", want.total_forced_presentations,
                          got.total_forced_presentations);
            compare_field("status", want.status, got.status);
        endfunction
    endclass

    logic      clk          = 1'b0;
    logic      rst_n        = 1'b0;
    logic      byte_valid   = 1'b0;
    logic      byte_stall;
    in_item_t  byte_item    = '0;
    logic      report_valid;
    logic      report_stall = 1'b0;
    out_item_t report_item;

    segment_report_board board;

    // Idle controls: each side flips between bursty and steady stretches;
    // calm shuts off all idling for the last part of the run.
    bit calm       = 1'b0;
    bit tx_gaps    = 1'b1;
    bit rx_gaps    = 1'b1;
    int rx_hold    = 0;
    int items_sent = 0;

    subtitle_segment_forced_counter_unit #(
        .COUNT_BITS(TOTAL_BITS)
    ) DUT (
        .clk(clk),
        .rst_n(rst_n),
        .byte_valid(byte_valid),
        .byte_stall(byte_stall),
        .byte_item(byte_item),
        .report_valid(report_valid),
        .report_stall(report_stall),
        .report_item(report_item)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Report side: hold stall high in random bursts.
    always @(posedge clk)
    begin
        if ($urandom_range(0, 79) == 0)
            rx_gaps = !rx_gaps;
        if (rx_hold == 0 && rx_gaps && !calm && $urandom_range(0, 9) == 0)
            rx_hold = $urandom_range(1, 19);
        report_stall <= (rx_hold != 0);
        if (rx_hold != 0)
            rx_hold = rx_hold - 1;
    end

    // Check every report transaction; values read here are the ones the
    // block saw at this edge.
    always @(posedge clk)
        if (rst_n && report_valid && !report_stall)
            board.check_report(report_item);

    // Offer one input transaction, maybe after an idle burst, and hold it
    // until the block takes it. Valid stays high into the next call.
    task automatic push_item(input logic op, input logic [7:0] value);
        in_item_t item;
        item.operation = op;
        item.data_byte = value;
        if ($urandom_range(0, 49) == 0)
            tx_gaps = !tx_gaps;
        if (tx_gaps && !calm && $urandom_range(0, 7) == 0)
        begin
            byte_valid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge clk);
        end
        byte_valid <= 1'b1;
        byte_item  <= item;
        @(posedge clk);
        while (byte_stall)
            @(posedge clk);
        board.take_byte(item);
        items_sent++;
    endtask

    // Send one segment: type, big-endian length, payload. A count of zero or
    // more writes the object count byte and sets the forced flag of each
    // object slot with the given odds; a cut of zero or more stops the
    // segment after that many bytes, header included.
    task automatic send_segment(input logic [7:0] kind, input int len, input int count,
                                input int force_pct, input int cut);
        int         last;
        int         off;
        logic [7:0] value;
        last = (cut >= 0 && cut < 3 + len) ? cut : 3 + len;
        for (int i = 0; i < last; i++)
        begin
            off   = i - 3;
            value = 8'($urandom);
            if (i == 0)
                value = kind;
            else if (i == 1)
                value = 8'(len >> 8);
            else if (i == 2)
                value = 8'(len);
            else if (count >= 0 && off == int'(PCS_COUNT_OFFSET))
                value = 8'(count);
            else if (count >= 0 && off >= int'(PCS_OBJ_BASE) &&
                     (off - int'(PCS_OBJ_BASE)) % OBJ_BYTES == int'(OBJ_FLAG_BYTE))
                value[FORCED_BIT] = ($urandom_range(0, 99) < force_pct);
            push_item(OP_DATA, value);
        end
    endtask

    // Mostly well-formed segments with random content; the rest are stray
    // end marks, truncated segments and, once errors are allowed,
    // inconsistent presentations and raw noise.
    task automatic random_traffic(input int quota, input bit allow_errors);
        int         stop_at;
        int         pick;
        int         count;
        int         len;
        logic [7:0] kind;
        stop_at = items_sent + quota;
        while (items_sent < stop_at)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 45)
            begin
                if ($urandom_range(0, 9) == 0)
                    count = $urandom_range(7, 30);
                else
                    count = $urandom_range(0, 6);
                send_segment(TYPE_PCS, int'(PCS_OBJ_BASE) + OBJ_BYTES * count, count,
                             $urandom_range(0, 100), -1);
            end
            else if (pick < 68)
            begin
                // Shape the payload like a presentation; other types must ignore it.
                case ($urandom_range(0, 3))
                    0: kind = TYPE_PDS;
                    1: kind = TYPE_ODS;
                    2: kind = TYPE_WDS;
                    default: kind = TYPE_END;
                endcase
                if ($urandom_range(0, 7) == 0)
                    len = $urandom_range(13, 200);
                else
                    len = $urandom_range(0, 12);
                send_segment(kind, len, $urandom_range(0, 8), 50, -1);
            end
            else if (pick < 76)
            begin
                kind = 8'($urandom);
                if (kind == TYPE_PCS && !allow_errors)
                    kind = TYPE_ODS;
                send_segment(kind, $urandom_range(0, 12), -1, 0, -1);
            end
            else if (pick < 82)
                push_item(OP_END, 8'($urandom));
            else if (pick < 90)
            begin
                // Cut inside the header or the payload, then end the stream.
                if ($urandom_range(0, 3) == 0)
                    len = $urandom_range(0, 65535);
                else
                    len = $urandom_range(0, 20);
                send_segment(8'($urandom), len, -1, 0,
                             $urandom_range(1, (len < 20 ? len : 20) + 2));
                push_item(OP_END, 8'($urandom));
            end
            else if (allow_errors && pick < 96)
            begin
                // Presentation whose length disagrees with its object count.
                count = $urandom_range(0, 6);
                case ($urandom_range(0, 2))
                    0: len = $urandom_range(0, 10);
                    1: len = int'(PCS_OBJ_BASE) + OBJ_BYTES * count
                             + int'($urandom_range(1, 9));
                    default: len = int'(PCS_OBJ_BASE) + OBJ_BYTES * count
                                   - int'($urandom_range(1, 7));
                endcase
                send_segment(TYPE_PCS, len, count, 60, -1);
            end
            else if (allow_errors)
            begin
                // Raw noise, resynced by an end mark.
                repeat ($urandom_range(1, 6)) push_item(OP_DATA, 8'($urandom));
                push_item(OP_END, 8'($urandom));
            end
        end
    endtask

    // Drop valid and wait until every owed report has come back.
    task automatic drain_reports();
        byte_valid <= 1'b0;
        @(posedge clk);
        while (board.awaited_reports.size() != 0)
            @(posedge clk);
    endtask

    initial
    begin
        board = new();
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        // Totals straight out of reset: all zero, status ok.
        push_item(OP_END, 8'hFF);
        // Zero type with zero length: reported at the length byte, unknown type.
        send_segment(8'h00, 0, -1, 0, -1);
        // Top type and top length, cut one byte into the payload: truncated.
        send_segment(8'hFF, 16'hFFFF, -1, 0, 4);
        push_item(OP_END, 8'h00);
        // Known end-of-display type with a single payload byte.
        send_segment(TYPE_END, 1, -1, 0, -1);
        // Partial headers are dropped without a truncation flag.
        send_segment(TYPE_PDS, 16'h1234, -1, 0, 2);
        push_item(OP_END, 8'h5A);
        send_segment(TYPE_WDS, 16'h00FF, -1, 0, 1);
        push_item(OP_END, 8'hA5);

        // Clean traffic first, while the sticky length error is still clear.
        random_traffic(350, 1'b0);

        // Hold the sender until the block has caught up completely.
        drain_reports();

        // Presentation too short to reach its count byte: latch the error.
        send_segment(TYPE_PCS, 5, 0, 0, -1);
        // One large presentation with every object forced.
        send_segment(TYPE_PCS, int'(PCS_OBJ_BASE) + OBJ_BYTES * 40, 40, 100, -1);

        random_traffic(250, 1'b1);
        calm = 1'b1;
        random_traffic(150, 1'b1);

        drain_reports();
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("Checked %0d segment reports and %0d end-of-stream reports",
                 board.segment_reports, board.totals_reports);
        $display("from %0d input transactions; forced objects %0d, presentations %0d.",
                 items_sent, board.obj_total, board.pres_total);
        if (board.failures == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

    initial
    begin
        #(WATCHDOG_NS);
        $display("FAILURE");
        $finish;
    end

endmodule
